// ----- hdl/ssd_pkg.sv -----
// Shared types, constants and helpers for the string splitter.
package ssd_pkg;

  // Sizing
  localparam int unsigned DELIM_MAX         = 8;
  localparam int unsigned POSITION_BITS     = 16;
  localparam int unsigned STRING_INDEX_BITS = 24;

  // Match window and register field widths
  localparam int unsigned WIN_DEPTH  = 8;
  localparam int unsigned WIN_AW     = 3;
  localparam int unsigned FILL_W     = 4;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned DELIM_W    = 64;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  // Input command codes
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELIM_BYTES = 2'd0,
    CFG_DELIM_LEN   = 2'd1,
    CFG_DROP_EMPTY  = 2'd2
  } cfg_idx_e;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [DELIM_W-1:0] delim_bytes;
    logic [LEN_W-1:0]   delim_len;
    logic               drop_empty;
  } cfg_t;

  // Per-block running state
  typedef struct packed {
    win_t                         win;
    logic [FILL_W-1:0]            fill;
    logic                         has_bytes;
    logic [POSITION_BITS-1:0]     slot;
    logic [STRING_INDEX_BITS-1:0] sidx;
    logic [POSITION_BITS-1:0]     max_slots;
  } state_t;

  // One result item
  typedef struct packed {
    logic [7:0]                   out_byte;
    logic                         byte_valid;
    logic                         token_end;
    logic [POSITION_BITS-1:0]     token_position;
    logic [STRING_INDEX_BITS-1:0] string_index;
    logic                         string_done;
    logic [POSITION_BITS-1:0]     max_token_count;
  } res_t;

  // Saturating increments
  function automatic logic [POSITION_BITS-1:0] pos_sat_inc(
    input logic [POSITION_BITS-1:0] v
  );
    return (&v) ? v : v + POSITION_BITS'(1);
  endfunction

  function automatic logic [STRING_INDEX_BITS-1:0] sidx_sat_inc(
    input logic [STRING_INDEX_BITS-1:0] v
  );
    return (&v) ? v : v + STRING_INDEX_BITS'(1);
  endfunction

endpackage

// ----- hdl/ssd_cfg_regs.sv -----
// Configuration registers of the string splitter.
module ssd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output ssd_pkg::cfg_t                    cfg_o
);
  import ssd_pkg::*;

  cfg_t cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DELIM_BYTES: cfg_q.delim_bytes <= cfg_data_i[DELIM_W-1:0];
        CFG_DELIM_LEN:   cfg_q.delim_len   <= cfg_data_i[LEN_W-1:0];
        CFG_DROP_EMPTY:  cfg_q.drop_empty  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/ssd_step.sv -----
// One step of the splitter: at most one result and the state that follows it.
module ssd_step (
  input  logic            cmd_i,
  input  logic [7:0]      byte_i,
  input  logic            pushed_i,
  input  ssd_pkg::state_t state_i,
  input  ssd_pkg::cfg_t   cfg_i,
  output ssd_pkg::state_t state_o,
  output logic            emit_o,
  output ssd_pkg::res_t   res_o,
  output logic            done_o
);
  import ssd_pkg::*;

  logic [LEN_W-1:0]         elen;
  win_t                     win_eff;
  win_t                     win_sh;
  logic [FILL_W-1:0]        fill_eff;
  logic                     match;
  logic                     kept;
  logic [POSITION_BITS-1:0] slots;
  logic [POSITION_BITS-1:0] new_max;

  // Lengths above the window size act as the window size
  assign elen = (cfg_i.delim_len > LEN_W'(DELIM_MAX)) ? LEN_W'(DELIM_MAX) : cfg_i.delim_len;

  // A fresh byte lands behind the bytes already held
  always_comb begin
    win_eff  = state_i.win;
    fill_eff = state_i.fill;
    if (cmd_i == CMD_BYTE && !pushed_i) begin
      win_eff[state_i.fill[WIN_AW-1:0]] = byte_i;
      fill_eff = state_i.fill + FILL_W'(1);
    end
  end

  // Window after its oldest byte leaves
  always_comb begin
    for (int i = 0; i < WIN_DEPTH - 1; i++) begin
      win_sh[i] = win_eff[i+1];
    end
    win_sh[WIN_DEPTH-1] = '0;
  end

  // Parallel compare of the leading bytes against the delimiter
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (LEN_W'(i) < elen && win_eff[i] != cfg_i.delim_bytes[8*i +: 8]) begin
        match = 1'b0;
      end
    end
  end

  // Slot count and running max for a string end
  always_comb begin
    if (elen == '0) begin
      kept  = state_i.has_bytes;
      slots = state_i.has_bytes ? pos_sat_inc(state_i.slot) : state_i.slot;
    end else begin
      kept  = !cfg_i.drop_empty || state_i.has_bytes;
      slots = pos_sat_inc(state_i.slot);
    end
    new_max = (slots > state_i.max_slots) ? slots : state_i.max_slots;
  end

  // Action selection
  always_comb begin
    state_o       = state_i;
    state_o.win   = win_eff;
    state_o.fill  = fill_eff;
    emit_o        = 1'b0;
    done_o        = 1'b1;
    res_o                 = '0;
    res_o.token_position  = state_i.slot;
    res_o.string_index    = state_i.sidx;
    res_o.max_token_count = state_i.max_slots;

    if (cmd_i == CMD_BYTE) begin
      if (elen == '0) begin
        // Every byte is a one-byte token
        if (fill_eff != '0) begin
          emit_o            = 1'b1;
          res_o.out_byte    = win_eff[0];
          res_o.byte_valid  = 1'b1;
          res_o.token_end   = 1'b1;
          state_o.win       = win_sh;
          state_o.fill      = fill_eff - FILL_W'(1);
          state_o.slot      = pos_sat_inc(state_i.slot);
          state_o.has_bytes = 1'b0;
          done_o            = (fill_eff == FILL_W'(1));
        end
      end else if (fill_eff > elen) begin
        // Window longer than the delimiter: oldest byte is token data
        emit_o            = 1'b1;
        res_o.out_byte    = win_eff[0];
        res_o.byte_valid  = 1'b1;
        state_o.win       = win_sh;
        state_o.fill      = fill_eff - FILL_W'(1);
        state_o.has_bytes = 1'b1;
        done_o            = 1'b0;
      end else if (fill_eff == elen) begin
        if (match) begin
          // Delimiter found: close the token, next slot
          emit_o            = !cfg_i.drop_empty || state_i.has_bytes;
          res_o.token_end   = 1'b1;
          state_o.slot      = pos_sat_inc(state_i.slot);
          state_o.has_bytes = 1'b0;
          state_o.fill      = '0;
        end else begin
          emit_o            = 1'b1;
          res_o.out_byte    = win_eff[0];
          res_o.byte_valid  = 1'b1;
          state_o.win       = win_sh;
          state_o.fill      = fill_eff - FILL_W'(1);
          state_o.has_bytes = 1'b1;
        end
      end
    end else begin
      if (fill_eff != '0) begin
        // Drain held bytes before closing the string
        emit_o           = 1'b1;
        res_o.out_byte   = win_eff[0];
        res_o.byte_valid = 1'b1;
        state_o.win      = win_sh;
        state_o.fill     = fill_eff - FILL_W'(1);
        done_o           = 1'b0;
        if (elen == '0) begin
          res_o.token_end   = 1'b1;
          state_o.slot      = pos_sat_inc(state_i.slot);
          state_o.has_bytes = 1'b0;
        end else begin
          state_o.has_bytes = 1'b1;
        end
      end else begin
        // Final result of the string
        emit_o                = 1'b1;
        res_o.token_end       = kept;
        res_o.string_done     = 1'b1;
        res_o.max_token_count = new_max;
        state_o.max_slots     = new_max;
        state_o.fill          = '0;
        state_o.has_bytes     = 1'b0;
        state_o.slot          = '0;
        state_o.sidx          = sidx_sat_inc(state_i.sidx);
      end
    end
  end

endmodule

// ----- hdl/ssd_core.sv -----
// Input register, running state and step control of the splitter.
module ssd_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          command_i,
  input  logic [7:0]    data_byte_i,
  input  ssd_pkg::cfg_t cfg_i,
  input  logic          adv_i,
  output logic          res_valid_o,
  output ssd_pkg::res_t res_o
);
  import ssd_pkg::*;

  logic       item_v_q;
  logic       item_cmd_q;
  logic [7:0] item_byte_q;
  logic       pushed_q;
  state_t     state_q;
  state_t     state_d;
  logic       emit;
  logic       done;
  logic       step_en;
  logic       accept;

  ssd_step u_step (
    .cmd_i    (item_cmd_q),
    .byte_i   (item_byte_q),
    .pushed_i (pushed_q),
    .state_i  (state_q),
    .cfg_i    (cfg_i),
    .state_o  (state_d),
    .emit_o   (emit),
    .res_o    (res_o),
    .done_o   (done)
  );

  // A step runs whenever an item is held and the result register has room
  assign step_en     = item_v_q && adv_i;
  assign in_ready_o  = !item_v_q || (step_en && done);
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = step_en && emit;

  // Item control and running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
      pushed_q <= 1'b0;
      state_q  <= '0;
    end else begin
      if (step_en) begin
        state_q <= state_d;
      end
      if (accept) begin
        item_v_q <= 1'b1;
        pushed_q <= 1'b0;
      end else if (step_en) begin
        item_v_q <= !done;
        pushed_q <= 1'b1;
      end
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_cmd_q  <= command_i;
      item_byte_q <= data_byte_i;
    end
  end

endmodule

// ----- hdl/ssd_out_reg.sv -----
// Result register between the step logic and the output channel.
module ssd_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ssd_pkg::res_t res_i,
  output logic          adv_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ssd_pkg::res_t res_o
);
  import ssd_pkg::*;

  logic out_v_q;
  res_t res_q;

  // Room when empty or when the held item leaves now
  assign adv_o = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv_o) begin
      out_v_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/string_split_on_delimiter_top.sv -----
// Top level of the streaming string splitter.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  input    | in_valid_i / in_ready_o | command_i, data_byte_i
//  output   | out_valid_o/out_ready_i | out_byte_o .. max_token_count_o
//  config   | cfg_we_i                | cfg_index_i, cfg_data_i
//
// An item is worked in steps: one per window byte released past the delimiter
// length, then one for the delimiter compare or the string close, so a byte normally
// needs one step and a string end one plus its held bytes; results are registered.
// Reset clears the config, valid flags, window fill and all counters, not the payloads.
// A stalled output holds its result; the step unit pauses until the result register
// frees, and input ready drops while an item is still being worked.
module string_split_on_delimiter_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    command_i,
  input  logic [7:0]                              data_byte_i,
  input  logic                                    cfg_we_i,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [7:0]                              out_byte_o,
  output logic                                    byte_valid_o,
  output logic                                    token_end_o,
  output logic [ssd_pkg::POSITION_BITS-1:0]       token_position_o,
  output logic [ssd_pkg::STRING_INDEX_BITS-1:0]   string_index_o,
  output logic                                    string_done_o,
  output logic [ssd_pkg::POSITION_BITS-1:0]       max_token_count_o
);
  import ssd_pkg::*;

  cfg_t cfg;
  res_t step_res;
  res_t out_res;
  logic step_valid;
  logic adv;

  ssd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ssd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .cfg_i       (cfg),
    .adv_i       (adv),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  ssd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_valid),
    .res_i       (step_res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  // Result fields to ports
  assign out_byte_o        = out_res.out_byte;
  assign byte_valid_o      = out_res.byte_valid;
  assign token_end_o       = out_res.token_end;
  assign token_position_o  = out_res.token_position;
  assign string_index_o    = out_res.string_index;
  assign string_done_o     = out_res.string_done;
  assign max_token_count_o = out_res.max_token_count;

endmodule

// ----- hdl/ssd_checker.sv -----
// Port-level checks for the string splitter, bound to its top level.
module ssd_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic [7:0]                            out_byte_o,
  input logic                                  byte_valid_o,
  input logic                                  token_end_o,
  input logic [ssd_pkg::POSITION_BITS-1:0]     token_position_o,
  input logic [ssd_pkg::STRING_INDEX_BITS-1:0] string_index_o,
  input logic                                  string_done_o,
  input logic [ssd_pkg::POSITION_BITS-1:0]     max_token_count_o
);
  import ssd_pkg::*;

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(token_position_o) && $stable(string_index_o) && $stable(token_end_o))
    else $error("result changed while stalled");

  // A string close carries no token byte
  a_done_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> !byte_valid_o && out_byte_o == 8'd0)
    else $error("string close carries a byte");

  // A byteless result that is not a string close must end a token
  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o && !string_done_o |-> token_end_o)
    else $error("empty result without token end");

  // A kept last token is counted in the running max
  a_max_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o && token_end_o
      |-> max_token_count_o > token_position_o || (&token_position_o))
    else $error("running max below closing slot count");

endmodule

bind string_split_on_delimiter_top ssd_checker u_ssd_checker (.*);
